[design/bfi_pkg.sv]
// Shared types and constants of the brainfuck interpreter core.
package bfi_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_STEP    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_UNM_CLOSE   = 2'd1;
  localparam logic [1:0] ERR_UNM_OPEN    = 2'd2;
  localparam logic [1:0] ERR_STORE_FULL  = 2'd3;

  // Command characters
  localparam logic [7:0] CH_OPEN  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE = 8'h5D; // ]
  localparam logic [7:0] CH_RIGHT = 8'h3E; // >
  localparam logic [7:0] CH_LEFT  = 8'h3C; // <
  localparam logic [7:0] CH_INC   = 8'h2B; // +
  localparam logic [7:0] CH_DEC   = 8'h2D; // -
  localparam logic [7:0] CH_OUT   = 8'h2E; // .
  localparam logic [7:0] CH_IN    = 8'h2C; // ,

  typedef struct packed {
    logic       latch;
    logic       prog_we;
    logic       len_inc;
    logic       push;
    logic       pop;
    logic       match_wr_open;
    logic       match_wr_close;
    logic       err_we;
    logic [1:0] err_code;
    logic       exec;
    logic       restart;
    logic       clr_we;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic err_nz;
    logic len_full;
    logic sd_full;
    logic sd_zero;
    logic pc_end;
    logic ch_open;
    logic ch_close;
    logic clr_last;
  } sts_t;

endpackage

[design/bfi_ram.sv]
// Generic single-port-write, registered-read RAM.
module bfi_ram #(
  parameter int W = 8,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

[design/bfi_ctrl.sv]
// Controller state machine of the brainfuck interpreter core.
module bfi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_kind,
  output logic          out_valid,
  input  logic          out_stall,
  input  bfi_pkg::sts_t sts,
  output bfi_pkg::cmd_t cmd
);
  import bfi_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_POP1, S_POP2, S_EXEC, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_after_r, fin_after_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    fin_after_nxt = fin_after_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_nxt = fin_after_r ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FIN;
          case (in_kind)
            KIND_LOAD: begin
              if (sts.err_nz) begin
              end else if (sts.len_full) begin
                cmd.err_we = 1'b1; cmd.err_code = ERR_STORE_FULL;
              end else if (sts.ch_open) begin
                if (sts.sd_full) begin
                  cmd.err_we = 1'b1; cmd.err_code = ERR_STORE_FULL;
                end else begin
                  cmd.push = 1'b1; cmd.prog_we = 1'b1; cmd.len_inc = 1'b1;
                end
              end else if (sts.ch_close) begin
                if (sts.sd_zero) begin
                  cmd.err_we = 1'b1; cmd.err_code = ERR_UNM_CLOSE;
                end else begin
                  cmd.pop = 1'b1; cmd.prog_we = 1'b1;
                  state_nxt = S_POP1;
                end
              end else begin
                cmd.prog_we = 1'b1; cmd.len_inc = 1'b1;
              end
            end
            KIND_STEP: begin
              if (sts.err_nz) begin
              end else if (!sts.sd_zero) begin
                cmd.err_we = 1'b1; cmd.err_code = ERR_UNM_OPEN;
              end else if (!sts.pc_end) begin
                state_nxt = S_EXEC;
              end
            end
            KIND_RESTART: begin
              cmd.restart   = 1'b1;
              fin_after_nxt = 1'b1;
              state_nxt     = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_POP1: begin
        cmd.match_wr_open = 1'b1;
        state_nxt = S_POP2;
      end
      S_POP2: begin
        cmd.match_wr_close = 1'b1;
        cmd.len_inc = 1'b1;
        state_nxt = S_FIN;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      fin_after_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fin_after_r <= fin_after_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
endmodule

[design/bfi_dp.sv]
// Datapath of the brainfuck interpreter core: memories, pointers, result word.
module bfi_dp #(
  parameter int PROG_DEPTH = 1024,
  parameter int TAPE_DEPTH = 32768,
  parameter int NEST_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_data,
  input  bfi_pkg::cmd_t cmd,
  output bfi_pkg::sts_t sts,
  output logic          out_out_valid,
  output logic [7:0]    out_out_byte,
  output logic          out_input_used,
  output logic          out_halted,
  output logic [1:0]    out_status
);
  import bfi_pkg::*;

  localparam int PW = $clog2(PROG_DEPTH);
  localparam int LW = PW + 1;
  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int NW = $clog2(NEST_DEPTH);
  localparam int SW = NW + 1;

  logic [LW-1:0] len_r, len_nxt, pc_r, pc_nxt;
  logic [TW-1:0] dp_r, dp_nxt, clr_r, clr_nxt;
  logic [SW-1:0] sd_r, sd_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [7:0]    data_r;
  logic [PW-1:0] open_r;
  logic          res_dot_r, res_used_r;
  logic [7:0]    res_byte_r;
  logic          o_dot_r, o_used_r, o_halt_r;
  logic [7:0]    o_byte_r;
  logic [1:0]    o_stat_r;

  logic [7:0]    prog_rdata, tape_rdata, tape_wdata;
  logic [PW-1:0] match_rdata, match_waddr, match_wdata, stack_rdata;
  logic          match_we, tape_we, tape_exec_we;
  logic [TW-1:0] tape_waddr;
  logic [7:0]    cell_new;

  bfi_ram #(.W(8), .D(PROG_DEPTH)) u_prog (
    .clk(clk), .we(cmd.prog_we), .waddr(len_r[PW-1:0]), .wdata(in_data),
    .raddr(pc_r[PW-1:0]), .rdata(prog_rdata)
  );

  assign match_we    = cmd.match_wr_open | cmd.match_wr_close;
  assign match_waddr = cmd.match_wr_open ? stack_rdata : len_r[PW-1:0];
  assign match_wdata = cmd.match_wr_open ? len_r[PW-1:0] : open_r;

  bfi_ram #(.W(PW), .D(PROG_DEPTH)) u_match (
    .clk(clk), .we(match_we), .waddr(match_waddr), .wdata(match_wdata),
    .raddr(pc_r[PW-1:0]), .rdata(match_rdata)
  );

  logic [SW-1:0] sd_dec;
  assign sd_dec = sd_r - SW'(1);

  bfi_ram #(.W(PW), .D(NEST_DEPTH)) u_stack (
    .clk(clk), .we(cmd.push), .waddr(sd_r[NW-1:0]), .wdata(len_r[PW-1:0]),
    .raddr(sd_dec[NW-1:0]), .rdata(stack_rdata)
  );

  assign tape_exec_we = cmd.exec && (prog_rdata == CH_INC || prog_rdata == CH_DEC ||
                                     prog_rdata == CH_IN);
  assign tape_we    = cmd.clr_we | tape_exec_we;
  assign tape_waddr = cmd.clr_we ? clr_r : dp_r;
  assign tape_wdata = cmd.clr_we ? 8'd0 : cell_new;

  bfi_ram #(.W(8), .D(TAPE_DEPTH)) u_tape (
    .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
    .raddr(dp_r), .rdata(tape_rdata)
  );

  always_comb begin
    cell_new = tape_rdata;
    case (prog_rdata)
      CH_INC:  cell_new = tape_rdata + 8'd1;
      CH_DEC:  cell_new = tape_rdata - 8'd1;
      CH_IN:   cell_new = data_r;
      default: cell_new = tape_rdata;
    endcase
  end

  always_comb begin
    len_nxt = len_r;
    pc_nxt  = pc_r;
    dp_nxt  = dp_r;
    clr_nxt = clr_r;
    sd_nxt  = sd_r;
    err_nxt = err_r;
    if (cmd.len_inc) len_nxt = len_r + LW'(1);
    if (cmd.push)    sd_nxt  = sd_r + SW'(1);
    if (cmd.pop)     sd_nxt  = sd_dec;
    if (cmd.err_we)  err_nxt = cmd.err_code;
    if (cmd.clr_we)  clr_nxt = clr_r + TW'(1);
    if (cmd.restart) begin
      pc_nxt  = '0;
      dp_nxt  = '0;
      clr_nxt = '0;
    end
    if (cmd.exec) begin
      pc_nxt = pc_r + LW'(1);
      case (prog_rdata)
        CH_RIGHT: dp_nxt = (dp_r == TW'(TAPE_DEPTH - 1)) ? '0 : dp_r + TW'(1);
        CH_LEFT:  dp_nxt = (dp_r == '0) ? TW'(TAPE_DEPTH - 1) : dp_r - TW'(1);
        CH_OPEN:  if (tape_rdata == 8'd0) pc_nxt = {1'b0, match_rdata} + LW'(1);
        CH_CLOSE: if (tape_rdata != 8'd0) pc_nxt = {1'b0, match_rdata} + LW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      pc_r  <= '0;
      dp_r  <= '0;
      clr_r <= '0;
      sd_r  <= '0;
      err_r <= ERR_NONE;
    end else begin
      len_r <= len_nxt;
      pc_r  <= pc_nxt;
      dp_r  <= dp_nxt;
      clr_r <= clr_nxt;
      sd_r  <= sd_nxt;
      err_r <= err_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      data_r     <= in_data;
      res_dot_r  <= 1'b0;
      res_used_r <= 1'b0;
      res_byte_r <= 8'd0;
    end
    if (cmd.match_wr_open) open_r <= stack_rdata;
    if (cmd.exec) begin
      res_dot_r  <= (prog_rdata == CH_OUT);
      res_byte_r <= (prog_rdata == CH_OUT) ? tape_rdata : 8'd0;
      res_used_r <= (prog_rdata == CH_IN);
    end
    if (cmd.fin) begin
      o_dot_r  <= res_dot_r;
      o_byte_r <= res_byte_r;
      o_used_r <= res_used_r;
      o_halt_r <= (err_r != ERR_NONE) || (pc_r >= len_r);
      o_stat_r <= err_r;
    end
  end

  assign sts.err_nz   = (err_r != ERR_NONE);
  assign sts.len_full = (len_r == LW'(PROG_DEPTH));
  assign sts.sd_full  = (sd_r == SW'(NEST_DEPTH));
  assign sts.sd_zero  = (sd_r == '0);
  assign sts.pc_end   = (pc_r >= len_r);
  assign sts.ch_open  = (in_data == CH_OPEN);
  assign sts.ch_close = (in_data == CH_CLOSE);
  assign sts.clr_last = (clr_r == TW'(TAPE_DEPTH - 1));

  assign out_out_valid  = o_dot_r;
  assign out_out_byte   = o_byte_r;
  assign out_input_used = o_used_r;
  assign out_halted     = o_halt_r;
  assign out_status     = o_stat_r;

`ifndef SYNTHESIS
  a_sd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sd_r <= SW'(NEST_DEPTH)) else $error("bracket stack overflow");
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= len_r) else $error("program counter past program end");
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != ERR_NONE |=> err_r == $past(err_r)) else $error("error code changed");
`endif
endmodule

[design/brainfuck_interpreter_core.sv]
// Per word: a load passes IDLE, FIN (a closing bracket IDLE, POP1, POP2, FIN); a step IDLE, EXEC, FIN (IDLE, FIN
// if nothing runs); restart IDLE, CLEAR, FIN. One word at a time; a step reads program/match, then tape RMW.
// Restart sweeps the tape RAM one cell a cycle; the input stalls during the sweep.
// Reset (rst_n low, synchronous) clears pointers, counters and error, then runs the
// same tape sweep before the first input word is taken.
// A finished result word is held in the output register while the next word is taken.
module brainfuck_interpreter_core #(
  parameter int PROG_DEPTH = 1024,
  parameter int TAPE_DEPTH = 32768,
  parameter int NEST_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_out_valid,
  output logic [7:0] out_out_byte,
  output logic       out_input_used,
  output logic       out_halted,
  output logic [1:0] out_status
);
  import bfi_pkg::*;

  cmd_t cmd; // controller commands
  sts_t sts; // datapath status

  bfi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  bfi_dp #(
    .PROG_DEPTH(PROG_DEPTH), .TAPE_DEPTH(TAPE_DEPTH), .NEST_DEPTH(NEST_DEPTH)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_out_valid(out_out_valid), .out_out_byte(out_out_byte),
    .out_input_used(out_input_used), .out_halted(out_halted),
    .out_status(out_status)
  );
endmodule

[tb/brainfuck_interpreter_core_tb.sv]
// Self-checking testbench of the brainfuck interpreter core: directed table, then random programs.
`timescale 1ns / 100ps

module brainfuck_interpreter_core_tb;
  import bfi_pkg::*;

  localparam int PROG_DEPTH = 1024;
  localparam int TAPE_DEPTH = 32768;
  localparam int NEST_DEPTH = 64;
  localparam logic [1:0] KIND_NONE = 2'd3;  // unknown kind, changes nothing
  localparam int N_ITEMS = 2000;

  // One result word, as the output ports carry it
  typedef struct packed {
    logic       emit;
    logic [7:0] byte_out;
    logic       used;
    logic       halted;
    logic [1:0] status;
  } res_t;

  // Directed row: typed rows carry their expectation, the rest go to the interpreter model
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    bit         typed;
    res_t       res;
  } row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_kind;
  logic [7:0] in_data;
  logic       out_valid;
  logic       out_stall;
  logic       out_out_valid;
  logic [7:0] out_out_byte;
  logic       out_input_used;
  logic       out_halted;
  logic [1:0] out_status;

  brainfuck_interpreter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_valid  (out_out_valid),
    .out_out_byte   (out_out_byte),
    .out_input_used (out_input_used),
    .out_halted     (out_halted),
    .out_status     (out_status)
  );

  // Interpreter state mirror
  logic [7:0]  prog_mem [PROG_DEPTH];
  logic [9:0]  pair_mem [PROG_DEPTH];
  logic [7:0]  tape_mem [TAPE_DEPTH];
  logic [9:0]  open_stk [NEST_DEPTH];
  logic [6:0]  nest_cnt;
  logic [10:0] prog_len;
  logic [10:0] pc;
  logic [14:0] dp;
  logic [1:0]  err;

  res_t exp_q[$];
  int   errors = 0;
  int   burst_left = 0;
  int   words_sent = 0;
  int   restarts = 0;
  logic in_acc;

  // Clock, 10 ns
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop; covers the reset sweep and every restart sweep several times over
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Acceptance seen at the rising edge, consumed by the driver on the next falling edge
  always @(posedge clk) in_acc <= rst_n && in_valid && !in_stall;

  // Receiver stall: the pattern steps in turn through none, light, heavy and periodic stalling
  int stall_cyc = 0;
  always @(negedge clk) begin
    stall_cyc <= stall_cyc + 1;
    case (stall_cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 9) < 3);
      2'd2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= (stall_cyc[2:0] >= 3'd5);
    endcase
  end

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        report("unexpected word", 8'h0, 8'h0);
      end else begin
        w = exp_q.pop_front();
        if (out_out_valid !== w.emit)
          report("out_valid", 8'(out_out_valid), 8'(w.emit));
        if (out_out_byte !== w.byte_out) report("out_byte", out_out_byte, w.byte_out);
        if (out_input_used !== w.used)
          report("input_used", 8'(out_input_used), 8'(w.used));
        if (out_halted !== w.halted) report("halted", 8'(out_halted), 8'(w.halted));
        if (out_status !== w.status) report("status", 8'(out_status), 8'(w.status));
      end
    end
  end

  // Interpreter model: advances the mirror by one word and returns its result
  task automatic interpret(input logic [1:0] k, input logic [7:0] d, output res_t r);
    logic [10:0] nxt;
    logic [9:0]  o;
    logic [7:0]  op;
    r = '0;
    if (k == KIND_LOAD && err == ERR_NONE) begin
      if (prog_len >= PROG_DEPTH) begin
        err = ERR_STORE_FULL;
      end else if (d == CH_OPEN && nest_cnt >= NEST_DEPTH) begin
        err = ERR_STORE_FULL;
      end else if (d == CH_CLOSE && nest_cnt == 0) begin
        err = ERR_UNM_CLOSE;
      end else begin
        if (d == CH_OPEN) begin
          open_stk[nest_cnt] = prog_len[9:0];
          nest_cnt++;
        end else if (d == CH_CLOSE) begin
          nest_cnt--;
          o = open_stk[nest_cnt];
          pair_mem[o] = prog_len[9:0];
          pair_mem[prog_len[9:0]] = o;
        end
        prog_mem[prog_len[9:0]] = d;
        prog_len++;
      end
    end else if (k == KIND_STEP && err == ERR_NONE) begin
      if (nest_cnt != 0) begin
        err = ERR_UNM_OPEN;
      end else if (pc < prog_len) begin
        op = prog_mem[pc[9:0]];
        nxt = pc + 11'd1;
        case (op)
          CH_RIGHT: dp = dp + 15'd1;   // 15-bit wrap is the tape wrap
          CH_LEFT:  dp = dp - 15'd1;
          CH_INC:   tape_mem[dp] = tape_mem[dp] + 8'd1;
          CH_DEC:   tape_mem[dp] = tape_mem[dp] - 8'd1;
          CH_OUT: begin
            r.emit = 1'b1;
            r.byte_out = tape_mem[dp];
          end
          CH_IN: begin
            tape_mem[dp] = d;
            r.used = 1'b1;
          end
          CH_OPEN:  if (tape_mem[dp] == 8'd0) nxt = {1'b0, pair_mem[pc[9:0]]} + 11'd1;
          CH_CLOSE: if (tape_mem[dp] != 8'd0) nxt = {1'b0, pair_mem[pc[9:0]]} + 11'd1;
          default: ;
        endcase
        pc = nxt;
      end
    end else if (k == KIND_RESTART) begin
      foreach (tape_mem[i]) tape_mem[i] = 8'h0;
      dp = '0;
      pc = '0;
    end
    r.halted = (err != ERR_NONE) || (pc >= prog_len);
    r.status = err;
  endtask

  // Send one word in bursts with random gaps; expectation queued once accepted
  task automatic send_word(input logic [1:0] k, input logic [7:0] d,
                           input bit typed = 0, input res_t want = '0);
    res_t r;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_data  <= d;
    do @(negedge clk); while (!in_acc);
    burst_left--;
    interpret(k, d, r);
    exp_q.push_back(typed ? want : r);
    if (k != KIND_NONE) words_sent++;
  endtask

  // A random bracket-balanced fragment of program text
  task automatic load_fragment();
    int n;
    int depth;
    logic [7:0] c;
    logic [7:0] cmds [6];
    cmds = '{CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN};
    n = $urandom_range(2, 12);
    depth = 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        6: if (depth < 4) begin
          c = CH_OPEN;
          depth++;
        end else c = CH_INC;
        7: if (depth > 0) begin
          c = CH_CLOSE;
          depth--;
        end else c = CH_DEC;
        8: begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_OPEN || c == CH_CLOSE) c = 8'h41;
        end
        default: c = cmds[$urandom_range(0, 5)];
      endcase
      send_word(KIND_LOAD, c);
      if ($urandom_range(0, 30) == 0) send_word(KIND_NONE, 8'($urandom_range(0, 255)));
    end
    repeat (depth) send_word(KIND_LOAD, CH_CLOSE);
  endtask

  row_t dir_rows [];

  initial begin
    int mode;
    in_valid  = 1'b0;
    in_kind   = KIND_LOAD;
    in_data   = 8'h0;
    out_stall = 1'b0;
    rst_n     = 1'b0;
    nest_cnt = '0; prog_len = '0; pc = '0; dp = '0; err = ERR_NONE;
    foreach (tape_mem[i]) tape_mem[i] = 8'h0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty program, pointer wrap below zero, cell wrap, input byte,
    // brackets that fall through, non-command bytes at the extremes, past-end step
    dir_rows = '{
      '{KIND_STEP, 8'h00, 1, '{1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE}},
      '{KIND_LOAD, CH_LEFT, 1, '{1'b0, 8'h00, 1'b0, 1'b0, ERR_NONE}},
      '{KIND_LOAD, CH_DEC, 0, '0},
      '{KIND_LOAD, CH_OUT, 0, '0},
      '{KIND_LOAD, CH_IN, 0, '0},
      '{KIND_LOAD, CH_OUT, 0, '0},
      '{KIND_LOAD, CH_RIGHT, 0, '0},
      '{KIND_LOAD, CH_INC, 0, '0},
      '{KIND_LOAD, CH_OPEN, 0, '0},
      '{KIND_LOAD, CH_DEC, 0, '0},
      '{KIND_LOAD, CH_CLOSE, 0, '0},
      '{KIND_LOAD, 8'h00, 0, '0},
      '{KIND_LOAD, 8'hFF, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 1, '{1'b1, 8'hFF, 1'b0, 1'b0, ERR_NONE}},
      '{KIND_STEP, 8'h5A, 0, '0},
      '{KIND_STEP, 8'hFF, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 0, '0},
      '{KIND_STEP, 8'h00, 1, '{1'b0, 8'h00, 1'b0, 1'b1, ERR_NONE}},
      '{KIND_NONE, 8'hA5, 0, '0},
      '{KIND_RESTART, 8'h00, 0, '0}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);

    // Random: balanced fragments appended, then runs of steps over them
    while (words_sent < N_ITEMS) begin
      if (prog_len < 900 && $urandom_range(0, 3) == 0) begin
        load_fragment();
      end else begin
        repeat ($urandom_range(1, 20)) send_word(KIND_STEP, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 15) == 0) send_word(KIND_NONE, 8'($urandom_range(0, 255)));
      // restart is a full tape sweep, so only a few
      if (restarts < 5 && $urandom_range(0, 60) == 0) begin
        send_word(KIND_RESTART, 8'($urandom_range(0, 255)));
        restarts++;
      end
      // drain mid-run with the input idle
      if (words_sent >= N_ITEMS / 2 && words_sent < N_ITEMS / 2 + 25) begin
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (exp_q.size() != 0);
      end
    end

    // Error is sticky until reset, so exactly one kind is exercised at the end
    mode = $urandom_range(0, 3);
    case (mode)
      0: send_word(KIND_LOAD, CH_CLOSE);
      1: begin
        send_word(KIND_LOAD, CH_OPEN);
        send_word(KIND_STEP, 8'h00);
      end
      2: while (err == ERR_NONE) send_word(KIND_LOAD, 8'h41);
      default: while (err == ERR_NONE) send_word(KIND_LOAD, CH_OPEN);
    endcase
    send_word(KIND_LOAD, CH_INC);
    send_word(KIND_STEP, 8'h00);
    send_word(KIND_RESTART, 8'h00);
    send_word(KIND_STEP, 8'hFF);
    send_word(KIND_NONE, 8'h00);

    in_valid <= 1'b0;
    do @(negedge clk); while (exp_q.size() != 0);
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
